// ===== hdl/afg_pkg.sv =====
// shared types and constants of the audio fade gain stage
package afg_pkg;

  localparam int GAIN_FRAC_BITS_DEF = 24;

  localparam int SAMPLE_W    = 16;
  localparam int MS_W        = 16;
  localparam int FRAME_CNT_W = 32;
  localparam int VOLUME_W    = 17;
  localparam int CHAN_W      = 2;
  localparam int RATE_W      = 18;
  localparam int APB_ADDR_W  = 4;
  localparam int APB_DATA_W  = 32;
  localparam int REG_IDX_W   = 2;

  // ms * rate needs this many bits
  localparam int DIVISOR_W = MS_W + RATE_W;
  localparam int MUL_A_W   = 32;

  localparam logic [VOLUME_W-1:0] VOL_UNITY     = VOLUME_W'(65536);
  localparam logic [VOLUME_W-1:0] VOLUME_RST    = VOLUME_W'(65536);
  localparam logic [CHAN_W-1:0]   CHAN_RST      = CHAN_W'(2);
  localparam logic [CHAN_W-1:0]   CHAN_MONO     = CHAN_W'(1);
  localparam logic [RATE_W-1:0]   RATE_RST      = RATE_W'(48000);
  localparam logic [MUL_A_W-1:0]  MS_PER_SECOND = MUL_A_W'(1000);

  localparam logic [REG_IDX_W-1:0] REG_VOLUME        = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_CHANNEL_COUNT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SAMPLE_RATE   = 2'd2;

  typedef enum logic [1:0] {
    MODE_FRAME,
    MODE_START,
    MODE_FADE_OUT,
    MODE_END
  } mode_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ML1,
    S_ML2,
    S_MR1,
    S_MR2,
    S_FIN,
    S_OUT,
    S_CM1,
    S_CM2,
    S_DLOAD,
    S_DIV,
    S_DSTEP
  } state_t;

endpackage

// ===== hdl/afg_if.sv =====
// valid/ready channels for input words and result words
interface afg_req_if import afg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic signed [SAMPLE_W-1:0] left_sample;
  logic signed [SAMPLE_W-1:0] right_sample;
  logic [MS_W-1:0]            fade_ms;

  modport source (output valid, mode, left_sample, right_sample, fade_ms, input ready);
  modport sink (input valid, mode, left_sample, right_sample, fade_ms, output ready);
endinterface

interface afg_rsp_if import afg_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       playing;
  logic [FRAME_CNT_W-1:0]     frames_played;

  modport source (output valid, left_out, right_out, playing, frames_played, input ready);
  modport sink (input valid, left_out, right_out, playing, frames_played, output ready);
endinterface

// ===== hdl/audio_fade_gain_stage.sv =====
// Per-frame linear fade and volume stage for 16-bit PCM. A frame word on a playing stream
// passes through S_ML1, S_ML2, S_MR1, S_MR2, S_FIN and S_OUT before the stage is ready
// again: one shared 32 x (GAIN_FRAC_BITS+1) multiplier forms sample*volume and then
// *gain, for left and then right. A frame word on a stopped stream goes straight to
// S_OUT. Start and fade-out commands that need a new fade step compute it with a
// restoring divider that retires one quotient bit per cycle; other commands leave
// the sequencer idle. A finished frame waits in an output register, so the next word is
// accepted while the result is still held; a frame that finds that register
// full waits in its last state. Registers sit on an APB port at byte
// addresses 0 (volume), 4 (channel_count) and 8 (sample_rate).
module audio_fade_gain_stage import afg_pkg::*; #(
  parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  afg_req_if.sink               req,
  afg_rsp_if.source             rsp
);

  localparam int GAIN_W = GAIN_FRAC_BITS + 1;
  localparam int MUL_B_W = GAIN_W;
  localparam int PROD_W = MUL_A_W + MUL_B_W;
  localparam int DVD_W = GAIN_FRAC_BITS + 10;
  localparam int DCNT_W = $clog2(DVD_W);
  localparam int SCALE_SH = GAIN_FRAC_BITS + 16;
  localparam logic [GAIN_W-1:0] UNITY = GAIN_W'(1) << GAIN_FRAC_BITS;
  localparam logic [DVD_W-1:0] START_DVD = DVD_W'(1000) << GAIN_FRAC_BITS;
  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(DVD_W - 1);

  state_t state, state_next;

  // configuration
  logic [VOLUME_W-1:0] volume;
  logic [CHAN_W-1:0]   channel_count;
  logic [RATE_W-1:0]   sample_rate;

  // fade state
  logic [GAIN_W-1:0]      gain;
  logic                   target_is_unity;
  logic [GAIN_W-1:0]      gain_step;
  logic                   stop_at_target;
  logic                   stopped;
  logic [FRAME_CNT_W-1:0] frame_count;

  // working registers
  logic                       cmd_start;
  logic [MS_W-1:0]            ms_r;
  logic signed [SAMPLE_W-1:0] left_r;
  logic signed [SAMPLE_W-1:0] right_r;
  logic [PROD_W-1:0]          prod;
  logic [DIVISOR_W-1:0]       divisor;
  logic [DVD_W-1:0]           dividend;
  logic [DIVISOR_W-1:0]       rem;
  logic [DCNT_W-1:0]          div_cnt;
  logic signed [SAMPLE_W-1:0] res_l;
  logic signed [SAMPLE_W-1:0] res_r;

  // output register
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] out_left;
  logic signed [SAMPLE_W-1:0] out_right;
  logic                       out_playing;
  logic [FRAME_CNT_W-1:0]     out_frames;

  logic                 accept;
  logic                 out_load;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  mode_t                req_mode;
  logic                 cfg_wr;
  logic [REG_IDX_W-1:0] cfg_idx;

  logic [VOLUME_W-1:0] vol_eff;
  logic [RATE_W-1:0]   rate_eff;
  logic [SAMPLE_W-1:0] mag_l;
  logic [SAMPLE_W-1:0] mag_r;
  logic [SAMPLE_W-1:0] mag_out;

  logic [GAIN_W-1:0] tgt;
  logic [GAIN_W:0]   gain_sum;
  logic [GAIN_W-1:0] gain_diff;
  logic [GAIN_W-1:0] gain_upd;
  logic              reached;

  logic [DIVISOR_W:0]   rem_sh;
  logic [DIVISOR_W:0]   rem_sub;
  logic                 quo_bit;
  logic [DIVISOR_W-1:0] rem_new;
  logic [GAIN_W-1:0]    step_clamped;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign cfg_idx  = paddr[APB_ADDR_W-1:2];
  assign accept   = req.valid && req.ready;
  assign req_mode = mode_t'(req.mode);

  assign rsp.valid         = out_valid;
  assign rsp.left_out      = out_left;
  assign rsp.right_out     = out_right;
  assign rsp.playing       = out_playing;
  assign rsp.frames_played = out_frames;

  always_comb begin
    unique case (cfg_idx)
      REG_VOLUME:        prdata = APB_DATA_W'(volume);
      REG_CHANNEL_COUNT: prdata = APB_DATA_W'(channel_count);
      REG_SAMPLE_RATE:   prdata = APB_DATA_W'(sample_rate);
      default:           prdata = '0;
    endcase
  end

  assign vol_eff  = (volume > VOL_UNITY) ? VOL_UNITY : volume;
  assign rate_eff = (sample_rate == '0) ? RATE_W'(1) : sample_rate;
  assign mag_l    = left_r[SAMPLE_W-1] ? SAMPLE_W'(-left_r) : SAMPLE_W'(left_r);
  assign mag_r    = right_r[SAMPLE_W-1] ? SAMPLE_W'(-right_r) : SAMPLE_W'(right_r);
  // truncation toward zero: scale the magnitude, then restore the sign
  assign mag_out  = prod[SCALE_SH +: SAMPLE_W];

  // one ramp step toward the target, clamped there
  assign tgt       = target_is_unity ? UNITY : '0;
  assign gain_sum  = {1'b0, gain} + {1'b0, gain_step};
  assign gain_diff = gain - tgt;
  always_comb begin
    if (gain_step == '0) begin
      gain_upd = gain;
    end else if (gain < tgt) begin
      gain_upd = (gain_sum > {1'b0, tgt}) ? tgt : gain_sum[GAIN_W-1:0];
    end else begin
      gain_upd = (gain_diff > gain_step) ? gain - gain_step : tgt;
    end
  end
  assign reached = (gain_step != '0) && (gain_upd == tgt);

  // restoring divider, one quotient bit per cycle
  assign rem_sh  = {rem, dividend[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign quo_bit = rem_sh >= {1'b0, divisor};
  assign rem_new = quo_bit ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];

  always_comb begin
    if (dividend == '0) begin
      step_clamped = GAIN_W'(1);
    end else if (dividend > DVD_W'(UNITY)) begin
      step_clamped = UNITY;
    end else begin
      step_clamped = dividend[GAIN_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          unique case (req_mode)
            MODE_FRAME: state_next = stopped ? S_OUT : S_ML1;
            MODE_START: state_next = (req.fade_ms != '0) ? S_CM1 : S_IDLE;
            MODE_FADE_OUT: begin
              if (!stopped && req.fade_ms != '0 && gain != '0) begin
                state_next = S_CM1;
              end
            end
            MODE_END: state_next = S_IDLE;
          endcase
        end
      end
      S_ML1:   state_next = S_ML2;
      S_ML2:   state_next = S_MR1;
      S_MR1:   state_next = S_MR2;
      S_MR2:   state_next = S_FIN;
      S_FIN:   state_next = S_OUT;
      S_OUT:   state_next = (!out_valid || rsp.ready) ? S_IDLE : S_OUT;
      S_CM1:   state_next = S_CM2;
      S_CM2:   state_next = S_DLOAD;
      S_DLOAD: state_next = S_DIV;
      S_DIV:   state_next = (div_cnt == DCNT_LAST) ? S_DSTEP : S_DIV;
      S_DSTEP: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer: handshake and multiplier operands
  always_comb begin
    req.ready = 1'b0;
    out_load  = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_ML1: begin
        mul_a = MUL_A_W'(mag_l);
        mul_b = MUL_B_W'(vol_eff);
      end
      S_ML2, S_MR2, S_CM2: begin
        mul_a = (state == S_CM2) ? MS_PER_SECOND : prod[MUL_A_W-1:0];
        mul_b = gain;
      end
      S_MR1: begin
        mul_a = MUL_A_W'(mag_r);
        mul_b = MUL_B_W'(vol_eff);
      end
      S_CM1: begin
        mul_a = MUL_A_W'(rate_eff);
        mul_b = MUL_B_W'(ms_r);
      end
      S_OUT: out_load = !out_valid || rsp.ready;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_a) * PROD_W'(mul_b);

    if (accept) begin
      cmd_start <= (req_mode == MODE_START);
      ms_r      <= req.fade_ms;
      left_r    <= req.left_sample;
      right_r   <= req.right_sample;
      res_l     <= '0;
      res_r     <= '0;
    end

    if (state == S_MR1) begin
      res_l <= left_r[SAMPLE_W-1] ? SAMPLE_W'(0 - mag_out) : mag_out;
    end
    if (state == S_FIN) begin
      if (channel_count == CHAN_MONO) begin
        res_r <= '0;
      end else begin
        res_r <= right_r[SAMPLE_W-1] ? SAMPLE_W'(0 - mag_out) : mag_out;
      end
    end

    if (state == S_CM2) begin
      divisor <= prod[DIVISOR_W-1:0];
    end
    if (state == S_DLOAD) begin
      dividend <= cmd_start ? START_DVD : prod[DVD_W-1:0];
      rem      <= '0;
    end
    if (state == S_DIV) begin
      dividend <= {dividend[DVD_W-2:0], quo_bit};
      rem      <= rem_new;
    end

    if (out_load) begin
      out_left    <= res_l;
      out_right   <= res_r;
      out_playing <= !stopped;
      out_frames  <= frame_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      volume          <= VOLUME_RST;
      channel_count   <= CHAN_RST;
      sample_rate     <= RATE_RST;
      gain            <= '0;
      target_is_unity <= 1'b1;
      gain_step       <= '0;
      stop_at_target  <= 1'b0;
      stopped         <= 1'b1;
      frame_count     <= '0;
      div_cnt         <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_wr) begin
        unique case (cfg_idx)
          REG_VOLUME:        volume <= pwdata[VOLUME_W-1:0];
          REG_CHANNEL_COUNT: channel_count <= pwdata[CHAN_W-1:0];
          REG_SAMPLE_RATE:   sample_rate <= pwdata[RATE_W-1:0];
          default: begin
          end
        endcase
      end

      if (accept) begin
        unique case (req_mode)
          MODE_FRAME: begin
            if (!stopped) begin
              gain        <= gain_upd;
              frame_count <= frame_count + 1'b1;
              if (reached) begin
                gain_step <= '0;
                if (stop_at_target) begin
                  stopped <= 1'b1;
                end
              end
            end
          end
          MODE_START: begin
            frame_count     <= '0;
            stop_at_target  <= 1'b0;
            stopped         <= 1'b0;
            target_is_unity <= 1'b1;
            if (req.fade_ms != '0) begin
              gain <= '0;
            end else begin
              gain      <= UNITY;
              gain_step <= '0;
            end
          end
          MODE_FADE_OUT: begin
            if (!stopped) begin
              if (req.fade_ms == '0) begin
                stopped <= 1'b1;
              end else begin
                target_is_unity <= 1'b0;
                stop_at_target  <= 1'b1;
                if (gain == '0) begin
                  gain_step <= UNITY;
                end
              end
            end
          end
          MODE_END: stopped <= 1'b1;
        endcase
      end

      if (state == S_DLOAD) begin
        div_cnt <= '0;
      end else if (state == S_DIV) begin
        div_cnt <= div_cnt + 1'b1;
      end
      if (state == S_DSTEP) begin
        gain_step <= step_clamped;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== hdl/afg_checker.sv =====
// port-level checks of the audio fade gain stage and their binding
module afg_checker import afg_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic [1:0]                 req_mode,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic signed [SAMPLE_W-1:0] rsp_left_out,
  input logic signed [SAMPLE_W-1:0] rsp_right_out,
  input logic                       rsp_playing
);

  // a result word stays offered until taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result word dropped before it was taken");

  // the sequencer is idle right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> req_ready)
    else $error("input not ready after reset");

  // accepting a frame word always leaves the sequencer busy
  a_frame_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready && (req_mode == MODE_FRAME) |=> !req_ready)
    else $error("ready after accepting a frame word");

  // a stopped stream is silent
  a_silent_when_stopped: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_playing |-> (rsp_left_out == '0) && (rsp_right_out == '0))
    else $error("nonzero samples on a stopped stream");

endmodule

bind audio_fade_gain_stage afg_checker u_afg_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_mode      (req.mode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_left_out  (rsp.left_out),
  .rsp_right_out (rsp.right_out),
  .rsp_playing   (rsp.playing)
);
